FILE: design/rpd_pkg.sv
// Shared types and constants for the run-length palette pixel decoder.
package rpd_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOTAL     = 1'd1;
    localparam int THRESH_W = 8;
    localparam int TOTAL_W  = 20;
    localparam logic [THRESH_W-1:0] SPLIT_RESET = 8'd128;

    // Input item modes
    localparam logic [1:0] MODE_PALETTE = 2'd0;
    localparam logic [1:0] MODE_BYTE    = 2'd1;
    localparam logic [1:0] MODE_START   = 2'd2;

    // Decoding constants
    localparam logic [7:0] REPEAT_BIAS = 8'd3;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // Operation queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One operation for the back part: a palette write or a pixel result.
    typedef struct packed {
        logic        is_write;
        logic [7:0]  index;
        logic [23:0] rgb;
        logic [7:0]  count;
        logic        done;
    } t_op;

    typedef struct packed {
        logic push;
        t_op  op;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

FILE: design/rpd_front.sv
// Front part: accepts input items, runs the run-length decode state and queues operations.
module rpd_front
    import rpd_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_data_byte,
    input  logic [7:0]          i_palette_index,
    input  logic [23:0]         i_palette_rgb,
    input  logic [THRESH_W-1:0] i_split_threshold,
    input  logic [TOTAL_W-1:0]  i_pixel_total,
    input  t_qstat              i_qstat,
    output t_push               o_push
);

    localparam int PW = PIXEL_COUNT_BITS;
    localparam logic [31:0] PIXEL_CAP =
        (PW >= 32) ? 32'hffff_ffff : ((32'd1 << PW) - 32'd1);

    // Decode phase codes
    localparam logic [1:0] PH_COUNT   = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_REPEAT  = 2'd2;

    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_literal_left, n_literal_left;
    logic [7:0]    r_run_length, n_run_length;
    logic [PW-1:0] r_pixels_left, n_pixels_left;

    logic          w_accept;
    logic [7:0]    w_emit_count;
    logic [7:0]    w_clamped;
    logic [PW-1:0] w_left_after;
    logic          w_done;
    logic [31:0]   w_total_ext;
    logic [PW-1:0] w_start_left;
    logic [7:0]    w_literal_len;

    assign w_accept = i_valid && !i_qstat.full;
    assign o_stall  = i_qstat.full;

    // Run length of a pixel result, clamped to the pixels left in the frame.
    assign w_emit_count = (r_phase == PH_REPEAT) ? r_run_length : 8'd1;
    assign w_clamped    = (r_pixels_left < PW'(w_emit_count)) ? r_pixels_left[7:0]
                                                              : w_emit_count;
    assign w_left_after = r_pixels_left - PW'(w_clamped);
    assign w_done       = (w_left_after == '0);

    // Frame size at start, saturated to the pixel counter width.
    assign w_total_ext  = 32'(i_pixel_total);
    assign w_start_left = (w_total_ext > PIXEL_CAP) ? PIXEL_CAP[PW-1:0]
                                                    : w_total_ext[PW-1:0];

    assign w_literal_len = i_data_byte - i_split_threshold + 8'd1;

    // Next decode state and the operation handed to the back part.
    always_comb begin
        n_phase        = r_phase;
        n_literal_left = r_literal_left;
        n_run_length   = r_run_length;
        n_pixels_left  = r_pixels_left;
        o_push.push        = 1'b0;
        o_push.op.is_write = 1'b0;
        o_push.op.index    = i_data_byte;
        o_push.op.rgb      = i_palette_rgb;
        o_push.op.count    = w_clamped;
        o_push.op.done     = w_done;

        if (w_accept) begin
            case (i_mode)
                MODE_PALETTE: begin
                    o_push.push        = 1'b1;
                    o_push.op.is_write = 1'b1;
                    o_push.op.index    = i_palette_index;
                end
                MODE_START: begin
                    n_pixels_left  = w_start_left;
                    n_phase        = PH_COUNT;
                    n_literal_left = 8'd0;
                    n_run_length   = 8'd0;
                end
                MODE_BYTE: begin
                    if (r_pixels_left != '0) begin
                        case (r_phase)
                            PH_LITERAL: begin
                                if (r_literal_left > 8'd1) begin
                                    n_literal_left = r_literal_left - 8'd1;
                                end else begin
                                    n_literal_left = 8'd0;
                                    n_phase        = PH_COUNT;
                                end
                                o_push.push   = 1'b1;
                                n_pixels_left = w_left_after;
                            end
                            PH_REPEAT: begin
                                n_phase = PH_COUNT;
                                if (r_run_length != 8'd0) begin
                                    o_push.push   = 1'b1;
                                    n_pixels_left = w_left_after;
                                end
                            end
                            PH_COUNT: begin
                                if (i_data_byte >= i_split_threshold) begin
                                    n_literal_left = w_literal_len;
                                    n_phase = (w_literal_len != 8'd0) ? PH_LITERAL
                                                                      : PH_COUNT;
                                end else begin
                                    n_run_length = i_data_byte + REPEAT_BIAS;
                                    n_phase      = PH_REPEAT;
                                end
                            end
                            default: begin
                                n_phase = PH_COUNT;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Decode state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_COUNT;
            r_literal_left <= 8'd0;
            r_run_length   <= 8'd0;
            r_pixels_left  <= '0;
        end else begin
            r_phase        <= n_phase;
            r_literal_left <= n_literal_left;
            r_run_length   <= n_run_length;
            r_pixels_left  <= n_pixels_left;
        end
    end

endmodule

FILE: design/rpd_queue.sv
// Short operation queue that decouples the front part from the back part.
module rpd_queue
    import rpd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output t_op    o_head,
    output t_qstat o_qstat
);

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_qstat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_head        = r_slot[r_rd_ptr];

    assign w_do_push = i_push.push && !o_qstat.full;
    assign w_do_pop  = i_pop && !o_qstat.empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = w_do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_push.op;
        end
    end

endmodule

FILE: design/rpd_back.sv
// Back part: palette memory, registered lookup and the output register.
module rpd_back
    import rpd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_head,
    input  t_qstat      i_qstat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_pixel_argb,
    output logic [7:0]  o_repeat_count,
    output logic        o_frame_done
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [23:0]   r_palette [PALETTE_ENTRIES];

    logic          r_s1_valid;
    logic [23:0]   r_s1_rgb;
    logic          r_s1_in_range;
    logic [7:0]    r_s1_count;
    logic          r_s1_done;

    logic          r_out_valid;
    logic [31:0]   r_out_argb;
    logic [7:0]    r_out_count;
    logic          r_out_done;

    logic          w_out_take;
    logic          w_s1_adv;
    logic          w_in_range;
    logic          w_read;
    logic [AW-1:0] w_addr;

    // Output register frees when empty or taken; lookup stage follows it.
    assign w_out_take = !r_out_valid || !i_stall;
    assign w_s1_adv   = !r_s1_valid || w_out_take;
    assign o_pop      = !i_qstat.empty && (i_head.is_write || w_s1_adv);
    assign w_read     = o_pop && !i_head.is_write;
    assign w_in_range = (9'(i_head.index) < 9'(PALETTE_ENTRIES));
    assign w_addr     = i_head.index[AW-1:0];

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.is_write && w_in_range) begin
            r_palette[w_addr] <= i_head.rgb;
        end
        if (w_read) begin
            r_s1_rgb <= r_palette[w_addr];
        end
    end

    // Lookup stage payload
    always_ff @(posedge i_clk) begin
        if (w_read) begin
            r_s1_in_range <= w_in_range;
            r_s1_count    <= i_head.count;
            r_s1_done     <= i_head.done;
        end
    end

    // Output register payload; an index beyond the palette reads as black.
    always_ff @(posedge i_clk) begin
        if (w_out_take && r_s1_valid) begin
            r_out_argb  <= {ALPHA_OPAQUE, r_s1_in_range ? r_s1_rgb : 24'd0};
            r_out_count <= r_s1_count;
            r_out_done  <= r_s1_done;
        end
    end

    // Valid flags of the two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_take) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_read) begin
                r_s1_valid <= 1'b1;
            end else if (w_out_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_argb   = r_out_argb;
    assign o_repeat_count = r_out_count;
    assign o_frame_done   = r_out_done;

endmodule

FILE: design/rle_palette_pixel_decoder.sv
// Top level of the run-length palette pixel decoder with its configuration registers.
//
// Usage: the input channel (i_valid / o_stall) carries one item per transfer: a palette
// write (mode 0), a stream byte (mode 1) or a frame start (mode 2). The output channel
// (o_valid / i_stall) carries one pixel result per transfer: an opaque ARGB color, the
// number of consecutive pixels that take it, and a flag on the result that ends the frame.
// Count bytes, starts, mode 3 and bytes outside a frame give no result.
// Configuration is written over i_cfg_valid / o_cfg_ready (always ready): index 0 is the
// split threshold, index 1 the frame pixel count; write only while the block is idle.
// Throughput: one input item per cycle while o_stall is low. The front decodes each
// byte in the cycle it is taken; a four-entry queue feeds the back, which reads the
// palette memory through one registered port and then loads the output register.
// The result of a byte passes through a queue slot, the lookup stage and the output
// register, in that order, before o_valid rises for it.
// When the receiver stalls, the output register and lookup stage hold, the queue fills,
// and o_stall rises once four operations wait.
// Reset clears the decode state (no frame armed), the queue and the valid flags; the
// split threshold returns to 128 and the pixel count to 0. The palette is not cleared.
module rle_palette_pixel_decoder
    import rpd_pkg::*;
#(
    parameter int PALETTE_ENTRIES  = 256,
    parameter int PIXEL_COUNT_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_mode,
    input  logic [7:0]            i_data_byte,
    input  logic [7:0]            i_palette_index,
    input  logic [23:0]           i_palette_rgb,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [31:0]           o_pixel_argb,
    output logic [7:0]            o_repeat_count,
    output logic                  o_frame_done,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [THRESH_W-1:0] r_split_threshold;
    logic [TOTAL_W-1:0]  r_pixel_total;

    t_push  w_push;
    t_qstat w_qstat;
    t_op    w_head;
    logic   w_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_threshold <= SPLIT_RESET;
            r_pixel_total     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SPLIT_THRESHOLD: r_split_threshold <= i_cfg_data[THRESH_W-1:0];
                CFG_PIXEL_TOTAL:     r_pixel_total     <= i_cfg_data[TOTAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rpd_front #(
        .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_data_byte      (i_data_byte),
        .i_palette_index  (i_palette_index),
        .i_palette_rgb    (i_palette_rgb),
        .i_split_threshold(r_split_threshold),
        .i_pixel_total    (r_pixel_total),
        .i_qstat          (w_qstat),
        .o_push           (w_push)
    );

    rpd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_pop  (w_pop),
        .o_head (w_head),
        .o_qstat(w_qstat)
    );

    rpd_back #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_argb  (o_pixel_argb),
        .o_repeat_count(o_repeat_count),
        .o_frame_done  (o_frame_done)
    );

    // The front never queues an operation into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push |-> !w_qstat.full)
        else $error("operation queued while the queue is full");

    // Every pixel result covers at least one pixel.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_repeat_count != 8'd0))
        else $error("pixel result with zero repeat count");

    // The back never pops from an empty queue.
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("operation popped from an empty queue");

endmodule
